// File: design/grt_pkg.sv
// Shared types, codes and constants for the glyph text renderer.
`timescale 1ns / 1ps

package grt_pkg;

  // Fixed geometry of the glyph store and of one glyph row.
  localparam int unsigned GLYPH_WIDTH          = 8;
  localparam int unsigned ADDR_W               = 13;
  localparam int unsigned STORE_DEPTH          = 1 << ADDR_W;
  localparam int unsigned MAX_GLYPH_HEIGHT_DEF = 32;

  // Field widths of items and registers.
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned PY_W      = COORD_W + 1;
  localparam int unsigned CMP_W     = COORD_W + 2;
  localparam int unsigned CLIP_W    = 14;
  localparam int unsigned EXTENT_W  = 15;
  localparam int unsigned STRIDE_W  = 17;
  localparam int unsigned GH_W      = 6;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned ROWADDR_W = 30;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [GH_W-1:0] GLYPH_HEIGHT_RST = GH_W'(16);
  localparam logic [7:0]      NEWLINE_CODE     = 8'd10;

  // Request kinds carried by req_type.
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BEGIN = 2'd1,
    REQ_CHAR  = 2'd2
  } req_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LEFT    = 3'd0,
    CFG_CLIP_TOP     = 3'd1,
    CFG_CLIP_WIDTH   = 3'd2,
    CFG_CLIP_HEIGHT  = 3'd3,
    CFG_LINE_STRIDE  = 3'd4,
    CFG_GLYPH_HEIGHT = 3'd5
  } cfg_reg_e;

  // Row sequencer states.
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // One glyph row travelling alongside its glyph store read.
  typedef struct packed {
    logic            valid;
    logic [PY_W-1:0] py;
    logic            last;
  } row_info_t;

endpackage

// File: design/glyph_text_renderer.sv
// Top level of the glyph text renderer: registers, pen state and output stage.
`timescale 1ns / 1ps

// Usage:
// Input items arrive on in_valid_i / in_stall_o; an item is taken at a clock edge
// with valid high and stall low. Font loads and begin items give no result, and
// neither does a newline. A drawn character walks all glyph rows, one row per
// cycle while the receiver does not stall, reading the glyph store once per row;
// rows outside the vertical clip window are walked but not sent. A character
// thus stalls the input while its rows are walked and while a row is in flight,
// and its results pass through the store read and then the output register.
// Results leave on out_valid_o / out_stall_i from an output register. While the
// receiver stalls, the row walk and the pending store read hold in place.
// Configuration writes use cfg_valid_i / cfg_ready_o and are always taken;
// make them only while the block is idle; the block does not enforce this.
// Reset clears the pen, colour and registers (glyph height 16); the glyph
// store is not cleared and must be loaded before glyphs are drawn.

module glyph_text_renderer import grt_pkg::*; #(
  parameter int unsigned MAX_GLYPH_HEIGHT = MAX_GLYPH_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic [ADDR_W-1:0]    font_index_i,
  input  logic [7:0]           font_byte_i,
  input  logic signed [COORD_W-1:0] begin_x_i,
  input  logic signed [COORD_W-1:0] begin_y_i,
  input  logic [COLOR_W-1:0]   text_color_i,
  input  logic [7:0]           char_code_i,
  // Output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ROWADDR_W-1:0] row_address_o,
  output logic signed [COORD_W-1:0] pen_x_o,
  output logic [7:0]           pixel_mask_o,
  output logic [COLOR_W-1:0]   pixel_color_o,
  output logic                 last_row_o
);

  localparam int unsigned RW = $clog2(MAX_GLYPH_HEIGHT + 1);

  // Configuration registers.
  logic [CLIP_W-1:0]   clip_left_q;
  logic [CLIP_W-1:0]   clip_top_q;
  logic [EXTENT_W-1:0] clip_width_q;
  logic [EXTENT_W-1:0] clip_height_q;
  logic [STRIDE_W-1:0] line_stride_q;
  logic [GH_W-1:0]     glyph_height_q;

  // Pen state.
  logic [COORD_W-1:0] pen_col_q, pen_col_d;
  logic [COORD_W-1:0] line_start_q, line_start_d;
  logic [COORD_W-1:0] pen_row_q, pen_row_d;
  logic [COLOR_W-1:0] draw_color_q, draw_color_d;

  // Per-character snapshot.
  logic [COORD_W-1:0] cur_x_q;
  logic [7:0]         mask_q;
  logic [7:0]         mask_d;

  logic               in_acc;
  logic               font_we;
  logic               draw_start;
  logic               is_newline;
  logic [RW-1:0]      height;
  logic               seq_busy;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data;
  row_info_t          row_info;
  logic               adv;

  logic signed [CMP_W-1:0] x0_ext;
  logic signed [CMP_W-1:0] xlo;
  logic signed [CMP_W-1:0] xhi;
  logic [COORD_W-1:0]      xhi_u;

  logic [ROWADDR_W-1:0] py_wide;
  logic [ROWADDR_W-1:0] stride_wide;
  logic                 out_valid_q;
  logic [ROWADDR_W-1:0] row_address_q;
  logic [COORD_W-1:0]   pen_x_q;
  logic [7:0]           pixel_mask_q;
  logic [COLOR_W-1:0]   pixel_color_q;
  logic                 last_row_q;

  // Configuration writes; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q    <= '0;
      clip_top_q     <= '0;
      clip_width_q   <= '0;
      clip_height_q  <= '0;
      line_stride_q  <= '0;
      glyph_height_q <= GLYPH_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CLIP_LEFT:    clip_left_q    <= cfg_data_i[CLIP_W-1:0];
        CFG_CLIP_TOP:     clip_top_q     <= cfg_data_i[CLIP_W-1:0];
        CFG_CLIP_WIDTH:   clip_width_q   <= cfg_data_i[EXTENT_W-1:0];
        CFG_CLIP_HEIGHT:  clip_height_q  <= cfg_data_i[EXTENT_W-1:0];
        CFG_LINE_STRIDE:  line_stride_q  <= cfg_data_i[STRIDE_W-1:0];
        CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_data_i[GH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Glyph height in use, saturated to the largest supported glyph.
  assign height = (glyph_height_q > GH_W'(MAX_GLYPH_HEIGHT)) ?
                  RW'(MAX_GLYPH_HEIGHT) : RW'(glyph_height_q);

  // Input stalls while a glyph is walked or its last row is still in flight.
  assign in_stall_o = seq_busy || row_info.valid;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_newline = (char_code_i == NEWLINE_CODE);

  // Request decode and pen updates.
  always_comb begin
    pen_col_d    = pen_col_q;
    line_start_d = line_start_q;
    pen_row_d    = pen_row_q;
    draw_color_d = draw_color_q;
    font_we      = 1'b0;
    draw_start   = 1'b0;
    if (in_acc) begin
      unique case (req_type_i)
        REQ_LOAD: begin
          font_we = 1'b1;
        end
        REQ_BEGIN: begin
          pen_col_d    = begin_x_i;
          line_start_d = begin_x_i;
          pen_row_d    = begin_y_i;
          draw_color_d = text_color_i;
        end
        REQ_CHAR: begin
          if (is_newline) begin
            pen_row_d = pen_row_q + COORD_W'(height);
            pen_col_d = line_start_q;
          end else begin
            pen_col_d  = pen_col_q + COORD_W'(GLYPH_WIDTH);
            draw_start = (height != '0);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_col_q    <= '0;
      line_start_q <= '0;
      pen_row_q    <= '0;
      draw_color_q <= '0;
    end else begin
      pen_col_q    <= pen_col_d;
      line_start_q <= line_start_d;
      pen_row_q    <= pen_row_d;
      draw_color_q <= draw_color_d;
    end
  end

  // Horizontal clip mask; bit 7 is the column at the pen.
  assign x0_ext = $signed(CMP_W'($signed(pen_col_q)));
  assign xhi_u  = COORD_W'({2'b00, clip_left_q}) + COORD_W'({1'b0, clip_width_q});
  assign xlo    = $signed(CMP_W'(clip_left_q));
  assign xhi    = $signed(CMP_W'(xhi_u));

  always_comb begin
    logic signed [CMP_W-1:0] px;
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      px = x0_ext + CMP_W'(c);
      mask_d[GLYPH_WIDTH-1-c] = (px >= xlo) && (px < xhi);
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_start) begin
      cur_x_q <= pen_col_q;
      mask_q  <= mask_d;
    end
  end

  // The whole row pipeline moves when the output register can take a row.
  assign adv = !out_valid_q || !out_stall_i;

  grt_glyph_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (font_index_i),
    .wdata_i (font_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  grt_row_seq #(
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (draw_start),
    .y0_i          (pen_row_q),
    .code_i        (char_code_i),
    .height_i      (height),
    .clip_top_i    (clip_top_q),
    .clip_height_i (clip_height_q),
    .adv_i         (adv),
    .busy_o        (seq_busy),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .row_o         (row_info)
  );

  // Row address: signed row times stride, kept to the low 30 bits.
  assign py_wide     = ROWADDR_W'($signed(row_info.py));
  assign stride_wide = ROWADDR_W'(line_stride_q);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= row_info.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && row_info.valid) begin
      row_address_q <= py_wide * stride_wide;
      pen_x_q       <= cur_x_q;
      pixel_mask_q  <= rd_data & mask_q;
      pixel_color_q <= draw_color_q;
      last_row_q    <= row_info.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_address_o = row_address_q;
  assign pen_x_o       = pen_x_q;
  assign pixel_mask_o  = pixel_mask_q;
  assign pixel_color_o = pixel_color_q;
  assign last_row_o    = last_row_q;

endmodule

// File: design/grt_glyph_ram.sv
// Glyph store: one write port and one registered read port.
`timescale 1ns / 1ps

module grt_glyph_ram import grt_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_q;

  // Font bytes are written one at a time.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is enabled, so a stalled row keeps its byte.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/grt_row_seq.sv
// Row sequencer: walks the rows of one glyph, issues store reads and vertical clipping.
`timescale 1ns / 1ps

module grt_row_seq import grt_pkg::*; #(
  parameter int unsigned MAX_GLYPH_HEIGHT = MAX_GLYPH_HEIGHT_DEF,
  localparam int unsigned RW = $clog2(MAX_GLYPH_HEIGHT + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COORD_W-1:0] y0_i,
  input  logic [7:0]         code_i,
  input  logic [RW-1:0]      height_i,
  input  logic [CLIP_W-1:0]  clip_top_i,
  input  logic [EXTENT_W-1:0] clip_height_i,
  input  logic               adv_i,
  output logic               busy_o,
  output logic               rd_en_o,
  output logic [ADDR_W-1:0]  rd_addr_o,
  output row_info_t          row_o
);

  seq_state_e          state_q, state_d;
  logic [RW-1:0]       row_q, row_d;
  logic [RW-1:0]       row_inc;
  logic [RW-1:0]       h_q;
  logic [ADDR_W-1:0]   base_q;
  logic [ADDR_W-1:0]   base_d;
  logic [COORD_W-1:0]  y0_q;
  logic signed [PY_W-1:0] py;
  logic signed [CMP_W-1:0] py_ext;
  logic signed [CMP_W-1:0] ylo;
  logic signed [CMP_W-1:0] yhi;
  logic [COORD_W-1:0]  yhi_u;
  logic                in_win;
  logic                last_row;
  row_info_t           row_q_info;

  // First store address of the glyph, wrapped to the store depth.
  assign base_d = ADDR_W'(code_i) * ADDR_W'(height_i);

  // Per-glyph snapshot taken when a character starts.
  always_ff @(posedge clk_i) begin
    if (start_i && state_q == SEQ_IDLE) begin
      h_q    <= height_i;
      base_q <= base_d;
      y0_q   <= y0_i;
    end
  end

  // Vertical position of the current row and its place in the clip window.
  assign row_inc = RW'(row_q + RW'(1));
  assign py      = $signed({y0_q[COORD_W-1], y0_q}) + $signed(PY_W'(row_q));
  assign py_ext  = CMP_W'(py);
  assign yhi_u   = COORD_W'({2'b00, clip_top_i}) + COORD_W'({1'b0, clip_height_i});
  assign ylo     = $signed(CMP_W'(clip_top_i));
  assign yhi     = $signed(CMP_W'(yhi_u));
  assign in_win  = (py_ext >= ylo) && (py_ext < yhi);
  // The window is contiguous, so a row is last at glyph end or when the next falls out.
  assign last_row = (row_inc == h_q) || ((py_ext + CMP_W'(1)) >= yhi);
  assign rd_addr_o = base_q + ADDR_W'(row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

  // Next state: one row per advancing cycle until the glyph height is reached.
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    rd_en_o = 1'b0;
    busy_o  = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          state_d = SEQ_RUN;
          row_d   = '0;
        end
      end
      SEQ_RUN: begin
        busy_o = 1'b1;
        if (adv_i) begin
          rd_en_o = 1'b1;
          row_d   = row_inc;
          if (row_inc == h_q) begin
            state_d = SEQ_IDLE;
          end
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  // Row information stage, aligned with the store read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q_info <= '0;
    end else if (adv_i) begin
      row_q_info.valid <= (state_q == SEQ_RUN) && in_win;
      row_q_info.py    <= py;
      row_q_info.last  <= last_row;
    end
  end

  assign row_o = row_q_info;

endmodule
